[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

[rtl/core/mbrm_pkg.sv]
package mbrm_pkg;

  localparam int PAYLOAD_MAX = 16;
  localparam int FRAME_MAX   = 128;

  localparam int IDX_W  = $clog2(PAYLOAD_MAX);
  localparam int STEP_W = ($clog2(PAYLOAD_MAX + 1) > 3) ? $clog2(PAYLOAD_MAX + 1) : 3;
  localparam int ADDR_W = 3;
  localparam int REQ_LEN = 8;
  localparam int REQ_CRC_BYTES = 6;

  localparam logic [8:0]  FRAME_LIM     = 9'(FRAME_MAX);
  localparam logic [8:0]  FRAME_OVERHEAD = 9'd5;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [7:0]  FUNC_HOLDING  = 8'h03;
  localparam logic [7:0]  FUNC_INPUT    = 8'h04;
  localparam logic [7:0]  SLAVE_RESET   = 8'd1;
  localparam logic [15:0] TIMEOUT_RESET = 16'd500;

  // input op codes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // completion status codes
  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_HEAD_TO = 3'd1;
  localparam logic [2:0] STAT_LONG    = 3'd2;
  localparam logic [2:0] STAT_BODY_TO = 3'd3;
  localparam logic [2:0] STAT_CRC     = 3'd4;
  localparam logic [2:0] STAT_ROOM    = 3'd5;

  // register index, taken from paddr[2]
  localparam logic REG_SLAVE_ADDR = 1'b0;
  localparam logic REG_TIMEOUT    = 1'b1;

  typedef enum logic [1:0] {
    JOB_REQ,
    JOB_DONE,
    JOB_FAIL
  } job_mode_t;

  typedef struct packed {
    logic              start;
    job_mode_t         mode;
    logic              fallback;
    logic [2:0]        status;
    logic [STEP_W-1:0] npay;
    logic [15:0]       address;
    logic [6:0]        count;
  } mbrm_job_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } mbrm_wr_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[rtl/core/mbrm_ctrl.sv]
module mbrm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [1:0]            op,
  input  logic [15:0]           start_address,
  input  logic [6:0]            register_count,
  input  logic [4:0]            payload_room,
  input  logic [7:0]            rx_byte,
  input  logic [15:0]           timeout_ticks,
  output mbrm_pkg::mbrm_job_t   job,
  output mbrm_pkg::mbrm_wr_t    wr
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEAD,
    PH_BODY
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic        fb_r, fb_nxt;
  logic [15:0] saddr_r, saddr_nxt;
  logic [6:0]  scount_r, scount_nxt;
  logic [4:0]  sroom_r, sroom_nxt;
  logic [7:0]  seen_r, seen_nxt;
  logic [7:0]  fbc_r, fbc_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic [15:0] timer_r, timer_nxt;

  logic [15:0] crc_fed;
  logic [15:0] timer_inc;
  logic [8:0]  body_end;
  logic [7:0]  idx;
  logic [4:0]  room_sat;
  logic        do_fail;
  logic        restart;
  logic [2:0]  fail_code;

  assign crc_fed   = mbrm_pkg::crc_feed(crc_r, rx_byte);
  assign timer_inc = (timer_r == 16'hFFFF) ? timer_r : timer_r + 16'd1;
  assign body_end  = 9'd3 + {1'b0, fbc_r};
  assign idx       = seen_r - 8'd3;
  assign room_sat  = ({3'b000, payload_room} > 8'(mbrm_pkg::PAYLOAD_MAX)) ?
                     5'(mbrm_pkg::PAYLOAD_MAX) : payload_room;

  always_comb begin
    phase_nxt  = phase_r;
    fb_nxt     = fb_r;
    saddr_nxt  = saddr_r;
    scount_nxt = scount_r;
    sroom_nxt  = sroom_r;
    seen_nxt   = seen_r;
    fbc_nxt    = fbc_r;
    crc_nxt    = crc_r;
    crc_lo_nxt = crc_lo_r;
    timer_nxt  = timer_r;
    job        = '0;
    wr         = '0;
    do_fail    = 1'b0;
    restart    = 1'b0;
    fail_code  = mbrm_pkg::STAT_OK;

    if (accept) begin
      case (op)
        mbrm_pkg::OP_START: begin
          saddr_nxt  = start_address;
          scount_nxt = register_count;
          sroom_nxt  = room_sat;
          fb_nxt     = 1'b0;
          job.start  = 1'b1;
          job.mode   = mbrm_pkg::JOB_REQ;
          restart    = 1'b1;
        end
        mbrm_pkg::OP_BYTE: begin
          if (phase_r != PH_IDLE) begin
            seen_nxt = seen_r + 8'd1;
            if (phase_r == PH_HEAD) begin
              crc_nxt = crc_fed;
              if (seen_r == 8'd2) begin
                fbc_nxt = rx_byte;
                if ({1'b0, rx_byte} + mbrm_pkg::FRAME_OVERHEAD > mbrm_pkg::FRAME_LIM) begin
                  do_fail   = 1'b1;
                  fail_code = mbrm_pkg::STAT_LONG;
                end else begin
                  phase_nxt = PH_BODY;
                  timer_nxt = '0;
                end
              end
            end else if ({1'b0, seen_r} < body_end) begin
              crc_nxt = crc_fed;
              if (idx < 8'(mbrm_pkg::PAYLOAD_MAX)) begin
                wr.we   = 1'b1;
                wr.addr = idx[mbrm_pkg::IDX_W-1:0];
                wr.data = rx_byte;
              end
            end else if ({1'b0, seen_r} == body_end) begin
              crc_lo_nxt = rx_byte;
            end else if ({rx_byte, crc_lo_r} != crc_r) begin
              do_fail   = 1'b1;
              fail_code = mbrm_pkg::STAT_CRC;
            end else if (fbc_r > {3'b000, sroom_r}) begin
              do_fail   = 1'b1;
              fail_code = mbrm_pkg::STAT_ROOM;
            end else begin
              job.start = 1'b1;
              job.mode  = mbrm_pkg::JOB_DONE;
              job.npay  = (fbc_r > 8'(mbrm_pkg::PAYLOAD_MAX)) ?
                          mbrm_pkg::STEP_W'(mbrm_pkg::PAYLOAD_MAX) :
                          fbc_r[mbrm_pkg::STEP_W-1:0];
              phase_nxt = PH_IDLE;
            end
          end
        end
        mbrm_pkg::OP_TICK: begin
          if (phase_r != PH_IDLE) begin
            timer_nxt = timer_inc;
            if (timer_inc >= timeout_ticks) begin
              do_fail   = 1'b1;
              fail_code = (phase_r == PH_HEAD) ? mbrm_pkg::STAT_HEAD_TO :
                                                 mbrm_pkg::STAT_BODY_TO;
            end
          end
        end
        default: ;
      endcase

      // first failure retries with function 0x04, second one reports
      if (do_fail) begin
        if (!fb_r) begin
          fb_nxt    = 1'b1;
          job.start = 1'b1;
          job.mode  = mbrm_pkg::JOB_REQ;
          restart   = 1'b1;
        end else begin
          job.start  = 1'b1;
          job.mode   = mbrm_pkg::JOB_FAIL;
          job.status = fail_code;
          phase_nxt  = PH_IDLE;
        end
      end

      if (restart) begin
        phase_nxt  = PH_HEAD;
        seen_nxt   = '0;
        fbc_nxt    = '0;
        crc_nxt    = mbrm_pkg::CRC_INIT;
        crc_lo_nxt = '0;
        timer_nxt  = '0;
      end
    end

    job.fallback = fb_nxt;
    job.address  = saddr_nxt;
    job.count    = scount_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      fb_r     <= 1'b0;
      saddr_r  <= '0;
      scount_r <= '0;
      sroom_r  <= '0;
      seen_r   <= '0;
      fbc_r    <= '0;
      crc_r    <= mbrm_pkg::CRC_INIT;
      crc_lo_r <= '0;
      timer_r  <= '0;
    end else begin
      phase_r  <= phase_nxt;
      fb_r     <= fb_nxt;
      saddr_r  <= saddr_nxt;
      scount_r <= scount_nxt;
      sroom_r  <= sroom_nxt;
      seen_r   <= seen_nxt;
      fbc_r    <= fbc_nxt;
      crc_r    <= crc_nxt;
      crc_lo_r <= crc_lo_nxt;
      timer_r  <= timer_nxt;
    end
  end

endmodule

[rtl/core/mbrm_emit.sv]
module mbrm_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  mbrm_pkg::mbrm_job_t job,
  input  mbrm_pkg::mbrm_wr_t  wr,
  input  logic [7:0]          slave_address,
  input  logic                out_stall,
  output logic                busy,
  output logic                out_valid,
  output logic [1:0]          out_kind,
  output logic [7:0]          out_data_byte,
  output logic [2:0]          out_status,
  output logic                out_function_used,
  output logic                out_last
);

  localparam int STEP_W = mbrm_pkg::STEP_W;
  localparam int IDX_W  = mbrm_pkg::IDX_W;

  // payload store, one byte per entry
  logic [7:0] store_mem [mbrm_pkg::PAYLOAD_MAX];
  logic [7:0] rdata_r;

  // sequencer
  logic                busy_r;
  mbrm_pkg::job_mode_t mode_r;
  logic                fb_r;
  logic [2:0]          code_r;
  logic [STEP_W-1:0]   npay_r;
  logic [STEP_W-1:0]   step_r;
  logic [15:0]         crc_r;
  logic [15:0]         addr_r;
  logic [6:0]          cnt_r;

  // stage 1 and output stage
  logic       s1_valid_r;
  logic [1:0] s1_kind_r;
  logic [7:0] s1_data_r;
  logic       s1_mem_r;
  logic [2:0] s1_status_r;
  logic       s1_fb_r;
  logic       s1_last_r;

  logic       out_valid_r;
  logic [1:0] out_kind_r;
  logic [7:0] out_data_r;
  logic [2:0] out_status_r;
  logic       out_fb_r;
  logic       out_last_r;

  logic [1:0] g_kind;
  logic [7:0] g_data;
  logic       g_mem;
  logic [2:0] g_status;
  logic       g_last;
  logic       adv_out;
  logic       s1_free;
  logic       fire;
  logic       rd_en;

  always_comb begin
    g_kind   = mbrm_pkg::KIND_TX;
    g_data   = '0;
    g_mem    = 1'b0;
    g_status = mbrm_pkg::STAT_OK;
    g_last   = 1'b0;
    case (mode_r)
      mbrm_pkg::JOB_REQ: begin
        g_last = (step_r == STEP_W'(mbrm_pkg::REQ_LEN - 1));
        case (step_r[2:0])
          3'd0: g_data = slave_address;
          3'd1: g_data = fb_r ? mbrm_pkg::FUNC_INPUT : mbrm_pkg::FUNC_HOLDING;
          3'd2: g_data = addr_r[15:8];
          3'd3: g_data = addr_r[7:0];
          3'd4: g_data = 8'h00;
          3'd5: g_data = {1'b0, cnt_r};
          3'd6: g_data = crc_r[7:0];
          3'd7: g_data = crc_r[15:8];
          default: g_data = '0;
        endcase
      end
      mbrm_pkg::JOB_DONE: begin
        if (step_r < npay_r) begin
          g_kind = mbrm_pkg::KIND_DATA;
          g_mem  = 1'b1;
        end else begin
          g_kind = mbrm_pkg::KIND_STATUS;
          g_last = 1'b1;
        end
      end
      mbrm_pkg::JOB_FAIL: begin
        g_kind   = mbrm_pkg::KIND_STATUS;
        g_status = code_r;
        g_last   = 1'b1;
      end
      default: ;
    endcase
  end

  assign adv_out = !out_valid_r || !out_stall;
  assign s1_free = !s1_valid_r || adv_out;
  assign fire    = busy_r && s1_free;
  assign rd_en   = fire && g_mem;
  assign busy    = busy_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      store_mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rdata_r <= store_mem[step_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (job.start) begin
        busy_r <= 1'b1;
        mode_r <= job.mode;
        fb_r   <= job.fallback;
        code_r <= job.status;
        npay_r <= job.npay;
        addr_r <= job.address;
        cnt_r  <= job.count;
        step_r <= '0;
        crc_r  <= mbrm_pkg::CRC_INIT;
      end else if (fire) begin
        step_r <= step_r + STEP_W'(1);
        if (g_last) begin
          busy_r <= 1'b0;
        end
        // request CRC runs one byte behind the transmit stream
        if (mode_r == mbrm_pkg::JOB_REQ && step_r < STEP_W'(mbrm_pkg::REQ_CRC_BYTES)) begin
          crc_r <= mbrm_pkg::crc_feed(crc_r, g_data);
        end
      end

      if (s1_free) begin
        s1_valid_r  <= fire;
        s1_kind_r   <= g_kind;
        s1_data_r   <= g_data;
        s1_mem_r    <= g_mem;
        s1_status_r <= g_status;
        s1_fb_r     <= fb_r;
        s1_last_r   <= g_last;
      end

      if (adv_out) begin
        out_valid_r  <= s1_valid_r;
        out_kind_r   <= s1_kind_r;
        out_data_r   <= s1_mem_r ? rdata_r : s1_data_r;
        out_status_r <= s1_status_r;
        out_fb_r     <= s1_fb_r;
        out_last_r   <= s1_last_r;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_data_byte     = out_data_r;
  assign out_status        = out_status_r;
  assign out_function_used = out_fb_r;
  assign out_last          = out_last_r;

endmodule

[rtl/core/modbus_rtu_read_master.sv]
// Modbus RTU read master. A byte or tick item is taken every cycle while
// in_stall is low and is handled in the cycle it is accepted; the protocol
// state lives in flops and the response payload is kept in a 16-entry byte
// store. Items that produce results hand a job to a result sequencer that
// emits one result per cycle when out_stall allows, through two register
// stages: a start or a retry puts out 8 request bytes (request CRC built
// serially), a good response puts out min(byte count, 16) payload bytes
// read from the store plus one status, a final failure one status. in_stall
// is high while the sequencer still has results to produce, so an item that
// causes results holds the input until all are issued, and longer once
// out_stall has backed up both output stages; the next item is taken while
// earlier results still wait at the output. Each result is registered in
// stage 1, then in the output stage. No clearing pass is needed after reset.
`include "assert_macros.svh"

module modbus_rtu_read_master (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_op,
  input  logic [15:0]                   in_start_address,
  input  logic [6:0]                    in_register_count,
  input  logic [4:0]                    in_payload_room,
  input  logic [7:0]                    in_rx_byte,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_kind,
  output logic [7:0]                    out_data_byte,
  output logic [2:0]                    out_status,
  output logic                          out_function_used,
  output logic                          out_last,

  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mbrm_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [7:0]          slave_addr_r;
  logic [15:0]         timeout_r;
  logic                accept;
  logic                busy;
  mbrm_pkg::mbrm_job_t job;
  mbrm_pkg::mbrm_wr_t  wr;

  assign pready   = 1'b1;
  assign accept   = in_valid && !in_stall;
  assign in_stall = busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= mbrm_pkg::SLAVE_RESET;
      timeout_r    <= mbrm_pkg::TIMEOUT_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        mbrm_pkg::REG_SLAVE_ADDR: slave_addr_r <= pwdata[7:0];
        mbrm_pkg::REG_TIMEOUT:    timeout_r    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      mbrm_pkg::REG_SLAVE_ADDR: prdata = {24'h000000, slave_addr_r};
      mbrm_pkg::REG_TIMEOUT:    prdata = {16'h0000, timeout_r};
      default:                  prdata = '0;
    endcase
  end

  mbrm_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .op             (in_op),
    .start_address  (in_start_address),
    .register_count (in_register_count),
    .payload_room   (in_payload_room),
    .rx_byte        (in_rx_byte),
    .timeout_ticks  (timeout_r),
    .job            (job),
    .wr             (wr)
  );

  mbrm_emit u_emit (
    .clk               (clk),
    .rst_n             (rst_n),
    .job               (job),
    .wr                (wr),
    .slave_address     (slave_addr_r),
    .out_stall         (out_stall),
    .busy              (busy),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_data_byte     (out_data_byte),
    .out_status        (out_status),
    .out_function_used (out_function_used),
    .out_last          (out_last)
  );

  `ASSERT_NEVER(a_store_wr_busy, clk, rst_n, wr.we && busy, "payload store written while results pending")
  `ASSERT_CLK(a_start_holds_input, clk, rst_n, accept && (in_op == mbrm_pkg::OP_START) |=> in_stall, "start item did not hold the input")
  `ASSERT_CLK(a_status_only_in_status, clk, rst_n, out_valid && (out_kind != mbrm_pkg::KIND_STATUS) |-> (out_status == mbrm_pkg::STAT_OK), "status code on a byte result")

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import mbrm_pkg::*;

  localparam logic [1:0] OP_VOID = 2'd3;
  localparam int LIMIT = 1_500_000;
  localparam int SETTLE = 24;
  localparam int SHOW_MAX = 40;

  typedef enum logic [1:0] {LINK_IDLE, LINK_HEAD, LINK_BODY} link_t;
  typedef enum logic [1:0] {RX_RAW, RX_CRC_LO, RX_CRC_HI, RX_CRC_BAD} rx_src_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] first_reg;
    logic [6:0]  reg_count;
    logic [4:0]  room;
    logic [7:0]  rx;
    rx_src_t     src;
    logic        checked;
    logic [2:0]  want;
  } line_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [2:0] status;
    logic       fn;
    logic       last;
  } reply_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_op;
  logic [15:0] in_start_address;
  logic [6:0]  in_register_count;
  logic [4:0]  in_payload_room;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_kind;
  logic [7:0]  out_data_byte;
  logic [2:0]  out_status;
  logic        out_function_used;
  logic        out_last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  modbus_rtu_read_master i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_start_address  (in_start_address),
    .in_register_count (in_register_count),
    .in_payload_room   (in_payload_room),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_data_byte     (out_data_byte),
    .out_status        (out_status),
    .out_function_used (out_function_used),
    .out_last          (out_last),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // master model: register copies and exchange state
  logic [7:0]  cfg_slave;
  logic [15:0] cfg_timeout;
  link_t       ph;
  logic        fb;
  logic [15:0] sv_addr;
  logic [6:0]  sv_cnt;
  logic [4:0]  sv_room;
  logic [7:0]  seen;
  logic [7:0]  blen;
  logic [15:0] crc_acc;
  logic [7:0]  crc_lo_rx;
  logic [15:0] ticks;
  logic [7:0]  store [PAYLOAD_MAX];

  reply_t replies_due [$];
  reply_t fresh [$];

  int faults;
  int checked_results;
  int status_seen;
  int work_items;
  int settings_used;
  int cycles;
  bit in_quiet;
  int in_mode_left;
  bit out_quiet;
  int out_mode_left;
  int stall_left;
  int roll;

  line_item_t plan [26] = '{
    '{OP_BYTE,  16'h0000, 7'd0,   5'd0,  8'h55, RX_RAW,     1'b0, STAT_OK},
    '{OP_TICK,  16'h1234, 7'd5,   5'd3,  8'h00, RX_RAW,     1'b0, STAT_OK},
    '{OP_VOID,  16'hFFFF, 7'd127, 5'd31, 8'hFF, RX_RAW,     1'b0, STAT_OK},
    '{OP_START, 16'hFFFF, 7'd125, 5'd31, 8'h00, RX_RAW,     1'b0, STAT_OK},
    '{OP_BYTE,  16'h0000, 7'd0,   5'd0,  8'h01, RX_RAW,     1'b0, STAT_OK},
    '{OP_BYTE,  16'h0000, 7'd0,   5'd0,  8'h03, RX_RAW,     1'b0, STAT_OK},
    '{OP_BYTE,  16'h0000, 7'd0,   5'd0,  8'h02, RX_RAW,     1'b0, STAT_OK},
    '{OP_BYTE,  16'h0000, 7'd0,   5'd0,  8'h00, RX_RAW,     1'b0, STAT_OK},
    '{OP_BYTE,  16'h0000, 7'd0,   5'd0,  8'hFF, RX_RAW,     1'b0, STAT_OK},
    '{OP_BYTE,  16'h0000, 7'd0,   5'd0,  8'h00, RX_CRC_LO,  1'b0, STAT_OK},
    '{OP_BYTE,  16'h0000, 7'd0,   5'd0,  8'h00, RX_CRC_HI,  1'b1, STAT_OK},
    '{OP_START, 16'h0000, 7'd1,   5'd0,  8'h00, RX_RAW,     1'b0, STAT_OK},
    '{OP_BYTE,  16'h0000, 7'd0,   5'd0,  8'hFF, RX_RAW,     1'b0, STAT_OK},
    '{OP_BYTE,  16'h0000, 7'd0,   5'd0,  8'h00, RX_RAW,     1'b0, STAT_OK},
    '{OP_BYTE,  16'h0000, 7'd0,   5'd0,  8'h7C, RX_RAW,     1'b0, STAT_OK},
    '{OP_BYTE,  16'h0000, 7'd0,   5'd0,  8'h01, RX_RAW,     1'b0, STAT_OK},
    '{OP_BYTE,  16'h0000, 7'd0,   5'd0,  8'h04, RX_RAW,     1'b0, STAT_OK},
    '{OP_BYTE,  16'h0000, 7'd0,   5'd0,  8'h01, RX_RAW,     1'b0, STAT_OK},
    '{OP_BYTE,  16'h0000, 7'd0,   5'd0,  8'hAB, RX_RAW,     1'b0, STAT_OK},
    '{OP_BYTE,  16'h0000, 7'd0,   5'd0,  8'h00, RX_CRC_BAD, 1'b0, STAT_OK},
    '{OP_BYTE,  16'h0000, 7'd0,   5'd0,  8'h00, RX_CRC_HI,  1'b1, STAT_CRC},
    '{OP_START, 16'h00FF, 7'd127, 5'd16, 8'h00, RX_RAW,     1'b0, STAT_OK},
    '{OP_TICK,  16'h0000, 7'd0,   5'd0,  8'h00, RX_RAW,     1'b0, STAT_OK},
    '{OP_TICK,  16'h0000, 7'd0,   5'd0,  8'h00, RX_RAW,     1'b0, STAT_OK},
    '{OP_TICK,  16'h0000, 7'd0,   5'd0,  8'h00, RX_RAW,     1'b0, STAT_OK},
    '{OP_START, 16'hA5A5, 7'd0,   5'd0,  8'h00, RX_RAW,     1'b0, STAT_OK}
  };

  task automatic report(input string what, input int got, input int want);
    faults++;
    if (faults <= SHOW_MAX)
      $display("[%0t] mismatch: %s got %0d want %0d", $time, what, got, want);
  endtask

  function automatic logic [15:0] crc16_fold(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  function automatic void reset_model();
    cfg_slave = SLAVE_RESET;
    cfg_timeout = TIMEOUT_RESET;
    ph = LINK_IDLE;
    fb = 1'b0;
    sv_addr = '0;
    sv_cnt = '0;
    sv_room = '0;
    seen = '0;
    blen = '0;
    crc_acc = CRC_INIT;
    crc_lo_rx = '0;
    ticks = '0;
    foreach (store[i]) store[i] = 8'h00;
  endfunction

  function automatic void emit(logic [1:0] kind, logic [7:0] data, logic [2:0] status);
    fresh.push_back('{kind, data, status, fb, 1'b0});
  endfunction

  function automatic void send_request();
    logic [7:0]  f [6];
    logic [15:0] c;
    f[0] = cfg_slave;
    f[1] = fb ? FUNC_INPUT : FUNC_HOLDING;
    f[2] = sv_addr[15:8];
    f[3] = sv_addr[7:0];
    f[4] = 8'h00;
    f[5] = {1'b0, sv_cnt};
    c = CRC_INIT;
    for (int i = 0; i < 6; i++) begin
      c = crc16_fold(c, f[i]);
      emit(KIND_TX, f[i], STAT_OK);
    end
    emit(KIND_TX, c[7:0], STAT_OK);
    emit(KIND_TX, c[15:8], STAT_OK);
    ph = LINK_HEAD;
    seen = '0;
    blen = '0;
    crc_acc = CRC_INIT;
    crc_lo_rx = '0;
    ticks = '0;
  endfunction

  // first failure retries with function 0x04, second one reports
  function automatic void give_up(logic [2:0] code);
    if (!fb) begin
      fb = 1'b1;
      send_request();
    end else begin
      emit(KIND_STATUS, 8'h00, code);
      ph = LINK_IDLE;
    end
  endfunction

  function automatic void take_byte(logic [7:0] b);
    int pos;
    int cnt;
    pos = seen;
    cnt = blen;
    seen = seen + 8'd1;
    if (ph == LINK_HEAD) begin
      crc_acc = crc16_fold(crc_acc, b);
      if (pos == 2) begin
        blen = b;
        if (int'(b) + 5 > FRAME_MAX) begin
          give_up(STAT_LONG);
        end else begin
          ph = LINK_BODY;
          ticks = '0;
        end
      end
    end else if (pos < 3 + cnt) begin
      crc_acc = crc16_fold(crc_acc, b);
      if (pos - 3 < PAYLOAD_MAX) store[pos - 3] = b;
    end else if (pos == 3 + cnt) begin
      crc_lo_rx = b;
    end else if ({b, crc_lo_rx} != crc_acc) begin
      give_up(STAT_CRC);
    end else if (cnt > int'(sv_room)) begin
      give_up(STAT_ROOM);
    end else begin
      for (int i = 0; i < cnt && i < PAYLOAD_MAX; i++) emit(KIND_DATA, store[i], STAT_OK);
      emit(KIND_STATUS, 8'h00, STAT_OK);
      ph = LINK_IDLE;
    end
  endfunction

  function automatic void apply_item(line_item_t it);
    reply_t tail;
    fresh.delete();
    case (it.op)
      OP_START: begin
        sv_addr = it.first_reg;
        sv_cnt = it.reg_count;
        sv_room = (it.room > 5'(PAYLOAD_MAX)) ? 5'(PAYLOAD_MAX) : it.room;
        fb = 1'b0;
        work_items++;
        send_request();
      end
      OP_BYTE: begin
        if (ph != LINK_IDLE) begin
          work_items++;
          take_byte(it.rx);
        end
      end
      OP_TICK: begin
        if (ph != LINK_IDLE) begin
          work_items++;
          if (ticks != 16'hFFFF) ticks++;
          if (ticks >= cfg_timeout) give_up(ph == LINK_HEAD ? STAT_HEAD_TO : STAT_BODY_TO);
        end
      end
      default: ;
    endcase
    if (fresh.size() > 0) begin
      tail = fresh.pop_back();
      tail.last = 1'b1;
      fresh.push_back(tail);
    end
    foreach (fresh[i]) replies_due.push_back(fresh[i]);
  endfunction

  function automatic int pick_gap();
    int r;
    if (in_mode_left == 0) begin
      in_quiet = !in_quiet;
      in_mode_left = $urandom_range(10, 60);
    end
    in_mode_left--;
    if (in_quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  function automatic line_item_t mk(logic [1:0] op, logic [7:0] rx, rx_src_t src);
    line_item_t it;
    it.op = op;
    it.first_reg = 16'($urandom);
    it.reg_count = 7'($urandom);
    it.room = 5'($urandom);
    it.rx = rx;
    it.src = src;
    it.checked = 1'b0;
    it.want = STAT_OK;
    return it;
  endfunction

  // entered and left at a falling edge
  task automatic drive_item(input line_item_t it);
    int gap;
    logic [7:0] rx;
    gap = pick_gap();
    case (it.src)
      RX_CRC_LO:  rx = crc_acc[7:0];
      RX_CRC_HI:  rx = crc_acc[15:8];
      RX_CRC_BAD: rx = crc_acc[7:0] ^ (8'h01 << $urandom_range(0, 7));
      default:    rx = it.rx;
    endcase
    it.rx = rx;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= it.op;
    in_start_address <= it.first_reg;
    in_register_count <= it.reg_count;
    in_payload_room <= it.room;
    in_rx_byte <= it.rx;
    do @(posedge clk); while (in_stall);
    apply_item(it);
    if (it.checked) begin
      if (fresh.size() == 0 || fresh[fresh.size() - 1].kind != KIND_STATUS)
        report("final status missing", -1, it.want);
      else if (fresh[fresh.size() - 1].status != it.want)
        report("model status", fresh[fresh.size() - 1].status, it.want);
    end
    @(negedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic idx, input logic [31:0] val);
    logic [31:0] want;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (wr) begin
      if (idx == REG_SLAVE_ADDR) cfg_slave = val[7:0];
      else cfg_timeout = val[15:0];
    end else begin
      want = (idx == REG_SLAVE_ADDR) ? {24'd0, cfg_slave} : {16'd0, cfg_timeout};
      if (prdata !== want) report("register read", prdata, want);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input logic [7:0] slave, input logic [15:0] limit_ticks);
    cfg_access(1'b1, REG_SLAVE_ADDR, {24'd0, slave});
    cfg_access(1'b1, REG_TIMEOUT, {16'd0, limit_ticks});
    cfg_access(1'b0, REG_SLAVE_ADDR, 32'd0);
    cfg_access(1'b0, REG_TIMEOUT, 32'd0);
    settings_used++;
  endtask

  // finish the exchange with random bytes and a too-long byte count in the header, then drain all results
  task automatic quiesce();
    while (ph != LINK_IDLE)
      drive_item(mk(OP_BYTE, (ph == LINK_HEAD && seen == 8'd2) ? 8'hFF : 8'($urandom), RX_RAW));
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    if (cfg_timeout > 16'd8 && $urandom_range(0, 15) == 0)
      drive_item(mk(OP_TICK, 8'($urandom), RX_RAW));
    drive_item(mk(OP_BYTE, b, RX_RAW));
  endtask

  task automatic send_header(input logic [7:0] n);
    send_byte(($urandom_range(0, 9) < 7) ? cfg_slave : 8'($urandom));
    send_byte(($urandom_range(0, 9) < 8) ? (fb ? FUNC_INPUT : FUNC_HOLDING) : 8'($urandom));
    send_byte(n);
  endtask

  task automatic send_frame(input int n, input bit good);
    send_header(8'(n));
    repeat (n) send_byte(8'($urandom));
    if (good) begin
      drive_item(mk(OP_BYTE, 8'h00, RX_CRC_LO));
      drive_item(mk(OP_BYTE, 8'h00, RX_CRC_HI));
    end else if ($urandom_range(0, 1) == 0) begin
      drive_item(mk(OP_BYTE, 8'h00, RX_CRC_BAD));
      drive_item(mk(OP_BYTE, 8'h00, RX_CRC_HI));
    end else begin
      drive_item(mk(OP_BYTE, 8'h00, RX_CRC_LO));
      drive_item(mk(OP_BYTE, crc_acc[15:8] ^ 8'($urandom_range(1, 255)), RX_RAW));
    end
  endtask

  task automatic answer();
    int pick;
    int n;
    logic fb0;
    pick = $urandom_range(0, 99);
    fb0 = fb;
    // timeouts only where the tick count stays short
    if (pick >= 70 && pick < 86 && cfg_timeout > 16'd40) pick = 0;
    if (pick < 62) begin
      n = $urandom_range(0, 99);
      if (n < 60) n = $urandom_range(0, sv_room);
      else if (n < 90) n = $urandom_range(0, 16);
      else n = $urandom_range(17, 123);
      send_frame(n, pick < 50);
    end else if (pick < 70) begin
      send_header(8'($urandom_range(124, 255)));
    end else if (pick < 78) begin
      repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
      while (ph == LINK_HEAD && fb == fb0) drive_item(mk(OP_TICK, 8'($urandom), RX_RAW));
    end else if (pick < 86) begin
      send_header(8'($urandom_range(4, 16)));
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
      while (ph == LINK_BODY && fb == fb0) drive_item(mk(OP_TICK, 8'($urandom), RX_RAW));
    end else if (pick < 94) begin
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 2))
          0:       drive_item(mk(OP_BYTE, 8'($urandom), RX_RAW));
          1:       drive_item(mk(OP_TICK, 8'($urandom), RX_RAW));
          default: drive_item(mk(OP_VOID, 8'($urandom), RX_RAW));
        endcase
      end
    end else begin
      // cut frame: leaves the receiver out of step
      send_header(8'($urandom_range(0, 16)));
      repeat ($urandom_range(0, 4)) send_byte(8'($urandom));
    end
  endtask

  task automatic run_exchange();
    line_item_t it;
    int tries;
    it = mk(OP_START, 8'($urandom), RX_RAW);
    it.reg_count = ($urandom_range(0, 9) < 8) ? 7'($urandom_range(1, 125)) : 7'($urandom);
    it.room = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(17, 31)) : 5'($urandom_range(0, 16));
    drive_item(it);
    tries = 0;
    while (ph != LINK_IDLE && tries < 3) begin
      // leave it busy now and then so the next start aborts it
      if ($urandom_range(0, 19) == 0) return;
      answer();
      tries++;
    end
  endtask

  always @(negedge clk) begin
    if (out_mode_left == 0) begin
      out_quiet = !out_quiet;
      out_mode_left = $urandom_range(20, 150);
    end
    out_mode_left--;
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (out_quiet) begin
      out_stall <= 1'b0;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        stall_left = $urandom_range(6, 24);
        out_stall <= 1'b1;
      end else begin
        out_stall <= (roll < 35);
      end
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (replies_due.size() == 0) begin
        report("result with none due, kind", out_kind, -1);
      end else begin
        want = replies_due.pop_front();
        checked_results++;
        if (out_kind == KIND_STATUS) status_seen++;
        if (out_kind !== want.kind) report("kind", out_kind, want.kind);
        if (out_data_byte !== want.data) report("data_byte", out_data_byte, want.data);
        if (out_status !== want.status) report("status", out_status, want.status);
        if (out_function_used !== want.fn)
          report("function_used", out_function_used, want.fn);
        if (out_last !== want.last) report("last", out_last, want.last);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timed out after %0d cycles with %0d results due", cycles, replies_due.size());
      $display("** modbus_rtu_read_master: FAILED **");
      $finish;
    end
  end

  initial begin
    int target;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_START;
    in_start_address = '0;
    in_register_count = '0;
    in_payload_room = '0;
    in_rx_byte = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    reset_model();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // registers come up at their reset values
    cfg_access(1'b0, REG_SLAVE_ADDR, 32'd0);
    cfg_access(1'b0, REG_TIMEOUT, 32'd0);
    cfg_access(1'b1, REG_TIMEOUT, 32'd3);
    foreach (plan[i]) drive_item(plan[i]);

    target = work_items;
    for (int m = 0; m < 5; m++) begin
      quiesce();
      case (m)
        0:       configure(8'h00, 16'd1);
        1:       configure(8'hFF, 16'd0);
        2:       configure(8'($urandom), 16'hFFFF);
        3:       configure(8'($urandom), 16'($urandom_range(2, 8)));
        default: configure(8'($urandom), 16'($urandom_range(9, 40)));
      endcase
      target += 44;
      while (work_items < target) run_exchange();
    end

    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("covered %0d working items over %0d register settings, with idle and", work_items,
             settings_used + 2);
    $display("unused ops mixed in; %0d results checked, %0d of them completion statuses",
             checked_results, status_seen);
    if (faults == 0) begin
      $display("** modbus_rtu_read_master: PASSED **");
    end else begin
      $display("%0d mismatches", faults);
      $display("** modbus_rtu_read_master: FAILED **");
    end
    $finish;
  end

endmodule
